>>> rtl/msa_cc_pkg.sv
// Shared types, constants and residue code tables for the column consensus block.
package msa_cc_pkg;

  localparam int NUM_SYMBOLS = 21;
  localparam int SYM_W = 5;
  localparam int GAP_INDEX = 20;
  localparam logic [7:0] GAP_CHAR = 8'h2D;
  localparam int CODON_LEN = 3;
  localparam int CNT_LIMIT = 8191;
  localparam int IDENT_W = 17;
  localparam int FRAC_BITS = 16;
  localparam int POS_W = 24;
  localparam int COORD_W = 25;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = 2;
  localparam logic [7:0] CASE_OFFSET = 8'h20;
  localparam logic [7:0] LOWER_FIRST = 8'h61;
  localparam logic [7:0] LOWER_LAST = 8'h7A;

  localparam logic [7:0] UPPER_CODES [NUM_SYMBOLS] = '{
    8'h41, 8'h56, 8'h4C, 8'h49, 8'h50, 8'h46, 8'h57, 8'h4D, 8'h47, 8'h53, 8'h54,
    8'h43, 8'h59, 8'h4E, 8'h51, 8'h44, 8'h45, 8'h4B, 8'h52, 8'h48, 8'h2D
  };

  localparam logic [7:0] LOWER_CODES [NUM_SYMBOLS] = '{
    8'h61, 8'h76, 8'h6C, 8'h69, 8'h70, 8'h66, 8'h77, 8'h6D, 8'h67, 8'h73, 8'h74,
    8'h63, 8'h79, 8'h6E, 8'h71, 8'h64, 8'h65, 8'h6B, 8'h72, 8'h68, 8'h2D
  };

  typedef struct packed {
    logic [7:0] residue;
    logic [7:0] ref_residue;
    logic       last_in_column;
  } in_t;

  typedef struct packed {
    logic [7:0]         consensus_residue;
    logic [7:0]         gap_filled_residue;
    logic [IDENT_W-1:0] identity_fraction;
    logic               coord_valid;
    logic [COORD_W-1:0] coord_start;
    logic [COORD_W-1:0] coord_end;
  } out_t;

  typedef struct packed {
    logic             known;
    logic [SYM_W-1:0] sym;
    logic             last;
    logic             ref_gap;
  } entry_t;

  function automatic logic [7:0] upper_code(input logic [SYM_W-1:0] idx);
    logic [7:0] code;
    code = UPPER_CODES[0];
    for (int k = 0; k < NUM_SYMBOLS; k++) begin
      if (idx == SYM_W'(k)) begin
        code = UPPER_CODES[k];
      end
    end
    return code;
  endfunction

  function automatic logic [7:0] lower_code(input logic [SYM_W-1:0] idx);
    logic [7:0] code;
    code = LOWER_CODES[0];
    for (int k = 0; k < NUM_SYMBOLS; k++) begin
      if (idx == SYM_W'(k)) begin
        code = LOWER_CODES[k];
      end
    end
    return code;
  endfunction

endpackage

>>> rtl/msa_column_consensus_top.sv
// Top level of the protein alignment column consensus block with its register port.
// Residues transfer in at one per cycle within a column while the four-entry queue has room.
// On the last residue of a column the back end stops taking entries while it scans the
// symbol counters for the first strict maximum, runs a restoring division for the Q1.16
// identity and loads the output register, which waits on out_ready. The queue absorbs up
// to four residues of the next column during that time.
// The only register is start_position at address 0 (reset value 1).
module msa_column_consensus_top #(
  parameter int MAX_SEQUENCES = 4096,
  parameter int MAX_COLUMNS = 8192
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  msa_cc_pkg::in_t       in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output msa_cc_pkg::out_t      out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [1:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import msa_cc_pkg::*;

  logic [POS_W-1:0] start_position;
  entry_t           front_entry;
  entry_t           q_entry;
  logic             q_valid;
  logic             q_ready;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {{(32 - POS_W){1'b0}}, start_position} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_position <= POS_W'(1);
    end else if (psel && penable && pwrite && pready && paddr == 2'd0) begin
      start_position <= pwdata[POS_W-1:0];
    end
  end

  msa_cc_front u_front (
    .in_data (in_data),
    .entry   (front_entry)
  );

  msa_cc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_entry (front_entry),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_entry  (q_entry)
  );

  msa_cc_back #(
    .MAX_SEQUENCES (MAX_SEQUENCES),
    .MAX_COLUMNS   (MAX_COLUMNS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_ready        (q_ready),
    .q_entry        (q_entry),
    .start_position (start_position),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data)
  );

endmodule

>>> rtl/msa_cc_front.sv
// Front end: upper-case and classify each residue into a symbol index.
module msa_cc_front (
  input  msa_cc_pkg::in_t    in_data,
  output msa_cc_pkg::entry_t entry
);
  import msa_cc_pkg::*;

  logic [7:0] folded;

  always_comb begin
    folded = in_data.residue;
    if (in_data.residue >= LOWER_FIRST && in_data.residue <= LOWER_LAST) begin
      folded = in_data.residue - CASE_OFFSET;
    end
    entry.known = 1'b0;
    entry.sym = '0;
    for (int k = 0; k < NUM_SYMBOLS; k++) begin
      if (folded == UPPER_CODES[k]) begin
        entry.known = 1'b1;
        entry.sym = SYM_W'(k);
      end
    end
    entry.last = in_data.last_in_column;
    entry.ref_gap = (in_data.ref_residue == GAP_CHAR);
  end

endmodule

>>> rtl/msa_cc_queue.sv
// Short queue of classified residues between front and back end.
module msa_cc_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  msa_cc_pkg::entry_t push_entry,
  output logic               pop_valid,
  input  logic               pop_ready,
  output msa_cc_pkg::entry_t pop_entry
);
  import msa_cc_pkg::*;

  entry_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (fill != (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid = (fill != '0);
  assign pop_entry = slots[rd_ptr];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

>>> rtl/msa_cc_back.sv
// Back end: count symbols, scan for the leader, divide for identity, emit the result.
module msa_cc_back #(
  parameter int MAX_SEQUENCES = 4096,
  parameter int MAX_COLUMNS = 8192
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_valid,
  output logic                             q_ready,
  input  msa_cc_pkg::entry_t               q_entry,
  input  logic [msa_cc_pkg::POS_W-1:0]     start_position,
  output logic                             out_valid,
  input  logic                             out_ready,
  output msa_cc_pkg::out_t                 out_data
);
  import msa_cc_pkg::*;

  localparam int CNT_CAP = (MAX_SEQUENCES < CNT_LIMIT) ? MAX_SEQUENCES : CNT_LIMIT;
  localparam int CNT_W = $clog2(CNT_CAP + 1);
  localparam int MAP_W = $clog2(MAX_COLUMNS + 1);
  localparam int STEP_W = $clog2(FRAC_BITS + 1);

  typedef enum logic [1:0] {S_COUNT, S_SCAN, S_DIV, S_EMIT} state_t;

  state_t              state;
  logic [CNT_W-1:0]    counts [NUM_SYMBOLS];
  logic [CNT_W-1:0]    seq;
  logic                ref_gap;
  logic [SYM_W-1:0]    scan_idx;
  logic [CNT_W-1:0]    best;
  logic [SYM_W-1:0]    lead;
  logic [SYM_W-1:0]    prev;
  logic [STEP_W-1:0]   div_step;
  logic [CNT_W:0]      rem;
  logic [IDENT_W-1:0]  quot;
  logic [MAP_W-1:0]    mapped;

  logic                pop;
  logic                take_lead;
  logic [CNT_W-1:0]    best_next;
  logic [CNT_W:0]      trial;
  logic                fits;
  logic                emit;
  logic [COORD_W-1:0]  base;

  assign q_ready = (state == S_COUNT);
  assign pop = q_valid && q_ready;
  assign take_lead = (counts[0] > best);
  assign best_next = take_lead ? counts[0] : best;
  assign trial = (div_step == '0) ? rem : {rem[CNT_W-1:0], 1'b0};
  assign fits = (trial >= {1'b0, seq});
  assign emit = (state == S_EMIT) && (!out_valid || out_ready);
  assign base = COORD_W'(start_position) + COORD_W'({mapped, 1'b0}) + COORD_W'(mapped);

  for (genvar k = 0; k < NUM_SYMBOLS; k++) begin : g_cnt
    always_ff @(posedge clk) begin
      if (rst) begin
        counts[k] <= '0;
      end else if (state == S_SCAN) begin
        if (k == NUM_SYMBOLS - 1) begin
          counts[k] <= '0;
        end else begin
          counts[k] <= counts[(k + 1) % NUM_SYMBOLS];
        end
      end else if (pop && q_entry.known && q_entry.sym == SYM_W'(k)
                   && counts[k] < CNT_W'(CNT_CAP)) begin
        counts[k] <= counts[k] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_COUNT;
      seq <= '0;
      mapped <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_COUNT: begin
          if (pop) begin
            if (seq < CNT_W'(CNT_CAP)) begin
              seq <= seq + 1'b1;
            end
            if (q_entry.last) begin
              ref_gap <= q_entry.ref_gap;
              scan_idx <= '0;
              best <= '0;
              lead <= '0;
              prev <= '0;
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          best <= best_next;
          if (take_lead) begin
            prev <= lead;
            lead <= scan_idx;
          end
          scan_idx <= scan_idx + 1'b1;
          if (scan_idx == SYM_W'(NUM_SYMBOLS - 1)) begin
            rem <= {1'b0, best_next};
            div_step <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem <= fits ? (trial - {1'b0, seq}) : trial;
          quot <= {quot[IDENT_W-2:0], fits};
          div_step <= div_step + 1'b1;
          if (div_step == STEP_W'(FRAC_BITS)) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit) begin
            out_data.consensus_residue <= upper_code(lead);
            out_data.gap_filled_residue <= (lead == SYM_W'(GAP_INDEX)) ? lower_code(prev)
                                                                        : upper_code(lead);
            out_data.identity_fraction <= quot;
            out_data.coord_valid <= !ref_gap;
            out_data.coord_start <= ref_gap ? '0 : base - 1'b1;
            out_data.coord_end <= ref_gap ? '0 : base + COORD_W'(CODON_LEN - 1);
            if (!ref_gap && mapped < MAP_W'(MAX_COLUMNS)) begin
              mapped <= mapped + 1'b1;
            end
            seq <= '0;
            state <= S_COUNT;
          end
        end
        default: begin
          state <= S_COUNT;
        end
      endcase
    end
  end

endmodule
